// ===== sv/assert_macros.svh =====
// Assertion helpers used by the dequantizer core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that stays active during reset.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/gavd_pkg.sv =====
package gavd_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FIELD_BITS    = 2'd0;
  localparam logic [1:0] CFG_VECTOR_LENGTH = 2'd1;
  localparam logic [1:0] CFG_GROUP_LENGTH  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [3:0]  FIELD_BITS_RST    = 4'd4;
  localparam logic [12:0] VECTOR_LENGTH_RST = 13'd128;
  localparam logic [12:0] GROUP_LENGTH_RST  = 13'd32;

  // Upper bound of the vector and group lengths.
  localparam logic [12:0] MAX_LEN = 13'd4096;

  // Floating point codes.
  localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;
  localparam logic [31:0] FP_QUIET_BIT   = 32'h0040_0000;

  // Request into the multiply-add unit.
  typedef struct packed {
    logic        start;
    logic [7:0]  raw;
    logic [31:0] scale;
    logic [31:0] offset;
  } fp_req_t;

  // Answer from the multiply-add unit.
  typedef struct packed {
    logic        done;
    logic [31:0] value;
  } fp_rsp_t;

endpackage

// ===== sv/gavd_fp_mac.sv =====
module gavd_fp_mac (
  input  logic              clk,
  input  logic              rst_n,
  input  gavd_pkg::fp_req_t req,
  output gavd_pkg::fp_rsp_t rsp
);

  // Round a positive integer v scaled by 2^(ebase-150) to single precision.
  function automatic logic [31:0] round_pack(input logic sgn, input logic [31:0] v,
                                             input logic [4:0] q,
                                             input logic signed [10:0] ebase);
    logic signed [10:0] be;
    logic signed [10:0] sh;
    logic [23:0] m;
    logic [24:0] m25;
    logic [31:0] mask;
    logic        rb;
    logic        st;
    logic [31:0] r;
    be = $signed({6'b0, q}) + ebase - 11'sd23;
    if (be < 11'sd1) be = 11'sd1;
    sh = be - ebase;
    if (sh <= 11'sd0) begin
      m    = 24'(v << 5'(-sh));
      rb   = 1'b0;
      st   = 1'b0;
      mask = '0;
    end else begin
      m    = 24'(v >> 5'(sh));
      rb   = v[5'(sh - 11'sd1)];
      mask = (32'd1 << 5'(sh - 11'sd1)) - 32'd1;
      st   = |(v & mask);
    end
    m25 = {1'b0, m} + 25'(rb & (st | m[0]));
    if (m25[24]) begin
      m  = m25[24:1];
      be = be + 11'sd1;
    end else begin
      m = m25[23:0];
    end
    if (be >= 11'sd255) r = {sgn, 8'hFF, 23'b0};
    else r = {sgn, (m[23] ? be[7:0] : 8'h00), m[22:0]};
    return r;
  endfunction

  // Index of the highest set bit.
  function automatic logic [4:0] msb_pos(input logic [31:0] v);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

  logic [5:0]  v_r;
  // product stages
  logic [31:0] p0_prod_r;
  logic [7:0]  p0_es_r;
  logic        p0_sgn_r;
  logic        p0_spec_r;
  logic [31:0] p0_specv_r;
  logic [31:0] p0_z_r;
  logic [4:0]  p1_q_r;
  logic [31:0] p1_prod_r;
  logic [7:0]  p1_es_r;
  logic        p1_sgn_r;
  logic        p1_spec_r;
  logic [31:0] p1_specv_r;
  logic [31:0] p1_z_r;
  logic [31:0] x2_r;
  logic [31:0] z2_r;
  // sum stages
  logic [27:0] s3_sum_r;
  logic [7:0]  s3_ea_r;
  logic        s3_sgn_r;
  logic        s3_zsgn_r;
  logic        s3_spec_r;
  logic [31:0] s3_specv_r;
  logic [4:0]  s4_q_r;
  logic        s4_zero_r;
  logic [27:0] s4_sum_r;
  logic [7:0]  s4_ea_r;
  logic        s4_sgn_r;
  logic        s4_zsgn_r;
  logic        s4_spec_r;
  logic [31:0] s4_specv_r;
  logic [31:0] res_r;

  // Operand decode of the scale.
  logic [23:0] sig_s;
  logic [7:0]  es_eff;
  logic        s_nan;
  logic        s_inf;
  always_comb begin
    sig_s  = {(req.scale[30:23] != 8'h00), req.scale[22:0]};
    es_eff = (req.scale[30:23] != 8'h00) ? req.scale[30:23] : 8'd1;
    s_nan  = (req.scale[30:23] == 8'hFF) && (req.scale[22:0] != 23'b0);
    s_inf  = (req.scale[30:23] == 8'hFF) && (req.scale[22:0] == 23'b0);
  end

  // Alignment of the addends, larger magnitude first.
  logic        xn, zn, xi, zi, swp, sub;
  logic [31:0] op_a, op_b;
  logic [23:0] sig_a, sig_b;
  logic [7:0]  ea, eb, dexp;
  logic [26:0] mb_full, mb, mb_mask;
  logic        a3_spec;
  logic [31:0] a3_specv;
  always_comb begin
    xn = (x2_r[30:23] == 8'hFF) && (x2_r[22:0] != 23'b0);
    zn = (z2_r[30:23] == 8'hFF) && (z2_r[22:0] != 23'b0);
    xi = (x2_r[30:23] == 8'hFF) && (x2_r[22:0] == 23'b0);
    zi = (z2_r[30:23] == 8'hFF) && (z2_r[22:0] == 23'b0);
    a3_spec  = xn | zn | xi | zi;
    if (xn) a3_specv = x2_r | gavd_pkg::FP_QUIET_BIT;
    else if (zn) a3_specv = z2_r | gavd_pkg::FP_QUIET_BIT;
    else if (xi && zi && (x2_r[31] != z2_r[31])) a3_specv = gavd_pkg::FP_DEFAULT_NAN;
    else if (xi) a3_specv = x2_r;
    else a3_specv = z2_r;
    swp   = (x2_r[30:0] < z2_r[30:0]);
    op_a  = swp ? z2_r : x2_r;
    op_b  = swp ? x2_r : z2_r;
    sub   = op_a[31] ^ op_b[31];
    sig_a = {(op_a[30:23] != 8'h00), op_a[22:0]};
    sig_b = {(op_b[30:23] != 8'h00), op_b[22:0]};
    ea    = (op_a[30:23] != 8'h00) ? op_a[30:23] : 8'd1;
    eb    = (op_b[30:23] != 8'h00) ? op_b[30:23] : 8'd1;
    dexp  = ea - eb;
    mb_full = {sig_b, 3'b000};
    mb_mask = '0;
    if (dexp >= 8'd27) begin
      mb = {26'b0, |sig_b};
    end else begin
      mb_mask = (27'd1 << dexp[4:0]) - 27'd1;
      mb = (mb_full >> dexp[4:0]) | {26'b0, |(mb_full & mb_mask)};
    end
  end

  // Pipeline of multiply, round, align, add and round.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[4:0], req.start};
    end
    // stage 0: integer product and special operands
    p0_prod_r <= 32'(req.raw) * 32'(sig_s);
    p0_es_r   <= es_eff;
    p0_sgn_r  <= req.scale[31];
    p0_z_r    <= req.offset;
    p0_spec_r <= s_nan | s_inf | (req.raw == 8'd0) | (sig_s == 24'd0);
    if (s_nan) p0_specv_r <= req.scale | gavd_pkg::FP_QUIET_BIT;
    else if (s_inf) p0_specv_r <= (req.raw == 8'd0) ? gavd_pkg::FP_DEFAULT_NAN : req.scale;
    else p0_specv_r <= {req.scale[31], 31'b0};
    // stage 1: leading one of the product
    p1_q_r     <= msb_pos(p0_prod_r);
    p1_prod_r  <= p0_prod_r;
    p1_es_r    <= p0_es_r;
    p1_sgn_r   <= p0_sgn_r;
    p1_spec_r  <= p0_spec_r;
    p1_specv_r <= p0_specv_r;
    p1_z_r     <= p0_z_r;
    // stage 2: product rounded to single precision
    x2_r <= p1_spec_r ? p1_specv_r
                      : round_pack(p1_sgn_r, p1_prod_r, p1_q_r, $signed({3'b0, p1_es_r}));
    z2_r <= p1_z_r;
    // stage 3: aligned add or subtract
    s3_sum_r   <= sub ? ({1'b0, sig_a, 3'b000} - {1'b0, mb})
                      : ({1'b0, sig_a, 3'b000} + {1'b0, mb});
    s3_ea_r    <= ea;
    s3_sgn_r   <= op_a[31];
    s3_zsgn_r  <= op_a[31] & op_b[31];
    s3_spec_r  <= a3_spec;
    s3_specv_r <= a3_specv;
    // stage 4: leading one of the sum
    s4_q_r     <= msb_pos({4'b0, s3_sum_r});
    s4_zero_r  <= (s3_sum_r == 28'd0);
    s4_sum_r   <= s3_sum_r;
    s4_ea_r    <= s3_ea_r;
    s4_sgn_r   <= s3_sgn_r;
    s4_zsgn_r  <= s3_zsgn_r;
    s4_spec_r  <= s3_spec_r;
    s4_specv_r <= s3_specv_r;
    // stage 5: sum rounded to nearest even
    if (s4_spec_r) res_r <= s4_specv_r;
    else if (s4_zero_r) res_r <= {s4_zsgn_r, 31'b0};
    else res_r <= round_pack(s4_sgn_r, {4'b0, s4_sum_r}, s4_q_r,
                             $signed({3'b0, s4_ea_r}) - 11'sd3);
  end

  assign rsp.done  = v_r[5];
  assign rsp.value = res_r;

endmodule

// ===== sv/group_affine_value_dequantizer_core.sv =====
// Group-wise affine dequantizer, one token vector at a time.
// Input beats (in_*): tuser is the opcode. Opcode 0 loads the next group's
// scale and offset into the group table; opcode 1 carries one packed byte.
// Result beats (out_*): one fp32 value raw*scale+offset per unpacked field,
// with its coordinate; tlast marks the last coordinate of the token and
// tuser marks the last result of the input beat.
// Configuration (cfg_*): field width, vector length and group length. The user
// must write them only while the block is idle; the block itself does not
// enforce this. cfg_ready is always high.
// Sequence: load beats and byte beats are taken in the idle state; a byte beat
// gives one to eight values. Per value, the extract state picks the field and
// reads the table, fp-start starts the six-stage multiply-add pipeline, fp-wait
// waits for its result and push loads the output register.
// New beats are taken once the last value of a beat sits in the output
// register. When the receiver stalls, the block holds that value and waits
// before pushing the next one.
// Reset clears counters, bit buffer and configuration to defaults; the group
// table holds nothing defined until loaded, and needs no clearing pass.
`include "assert_macros.svh"

module group_affine_value_dequantizer_core #(
  parameter int MAX_GROUPS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: payload_byte [7:0], scale_word [39:8], offset_word [71:40]
  input  logic [71:0] in_tdata,
  // in_tuser: opcode
  input  logic        in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: value_word [31:0], coord_index [43:32], zero fill [47:44]
  output logic [47:0] out_tdata,
  // out_tuser: item_end
  output logic        out_tuser,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int WW = $clog2(MAX_GROUPS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_EXTRACT, S_FP_START, S_FP_WAIT, S_PUSH
  } state_t;

  state_t      state_r;
  logic [3:0]  fbits_r;
  logic [12:0] vlen_r;
  logic [12:0] glen_r;
  logic [14:0] holder_r;
  logic [3:0]  held_r;
  logic [11:0] coord_r;
  logic [11:0] pos_r;
  logic [GW-1:0] rd_idx_r;
  logic [WW-1:0] wr_idx_r;
  logic [2:0]  n_r;
  logic [7:0]  raw_r;
  logic [11:0] fcoord_r;
  logic        flast_r;
  logic        more_r;
  logic [31:0] res_r;
  logic [31:0] oval_r;
  logic [11:0] ocoord_r;
  logic        olast_r;
  logic        oend_r;
  logic        ovalid_r;
  logic [63:0] mem_q_r;
  logic [63:0] mem [MAX_GROUPS];

  gavd_pkg::fp_req_t fp_req;
  gavd_pkg::fp_rsp_t fp_rsp;

  // Effective configuration after clamping.
  logic [3:0]  fb;
  logic [12:0] vlen;
  logic [12:0] glen;
  always_comb begin
    fb   = (fbits_r == 4'd0) ? 4'd1 : ((fbits_r > 4'd8) ? 4'd8 : fbits_r);
    vlen = (vlen_r == 13'd0) ? 13'd1
         : ((vlen_r > gavd_pkg::MAX_LEN) ? gavd_pkg::MAX_LEN : vlen_r);
    glen = (glen_r == 13'd0) ? 13'd1
         : ((glen_r > gavd_pkg::MAX_LEN) ? gavd_pkg::MAX_LEN : glen_r);
  end

  // Field extraction and position bookkeeping.
  logic        in_acc;
  logic        last_c;
  logic [3:0]  held_left;
  logic        more_c;
  logic [12:0] pos_inc;
  logic [14:0] holder_nxt;
  always_comb begin
    in_acc     = in_tvalid & in_tready;
    last_c     = ({1'b0, coord_r} + 13'd1) >= vlen;
    held_left  = held_r - fb;
    more_c     = !last_c && (held_left >= fb) && (n_r < 3'd7);
    pos_inc    = {1'b0, pos_r} + 13'd1;
    holder_nxt = holder_r | 15'({7'b0, in_tdata[7:0]} << held_r);
  end

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // Group table: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && in_acc && !in_tuser && (wr_idx_r < WW'(MAX_GROUPS))) begin
      mem[wr_idx_r[GW-1:0]] <= {in_tdata[71:40], in_tdata[39:8]};
    end
    mem_q_r <= mem[rd_idx_r];
  end

  always_comb begin
    fp_req.start  = (state_r == S_FP_START);
    fp_req.raw    = raw_r;
    fp_req.scale  = mem_q_r[31:0];
    fp_req.offset = mem_q_r[63:32];
  end

  gavd_fp_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (fp_req),
    .rsp   (fp_rsp)
  );

  // Sequencer, counters and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fbits_r  <= gavd_pkg::FIELD_BITS_RST;
      vlen_r   <= gavd_pkg::VECTOR_LENGTH_RST;
      glen_r   <= gavd_pkg::GROUP_LENGTH_RST;
      holder_r <= '0;
      held_r   <= '0;
      coord_r  <= '0;
      pos_r    <= '0;
      rd_idx_r <= '0;
      wr_idx_r <= '0;
      n_r      <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          gavd_pkg::CFG_FIELD_BITS:    fbits_r <= cfg_data[3:0];
          gavd_pkg::CFG_VECTOR_LENGTH: vlen_r  <= cfg_data;
          gavd_pkg::CFG_GROUP_LENGTH:  glen_r  <= cfg_data;
          default: ;
        endcase
      end
      // In the push state the output register is refilled instead.
      if (ovalid_r && out_tready && (state_r != S_PUSH)) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_tuser) begin
              holder_r <= holder_nxt;
              held_r   <= held_r + 4'd8;
              n_r      <= '0;
              state_r  <= S_EXTRACT;
            end else if (wr_idx_r < WW'(MAX_GROUPS)) begin
              wr_idx_r <= wr_idx_r + WW'(1);
            end
          end
        end
        S_EXTRACT: begin
          raw_r    <= 8'(holder_r & ((15'd1 << fb) - 15'd1));
          fcoord_r <= coord_r;
          flast_r  <= last_c;
          more_r   <= more_c;
          n_r      <= n_r + 3'd1;
          if (last_c) begin
            holder_r <= '0;
            held_r   <= '0;
            coord_r  <= '0;
            pos_r    <= '0;
            rd_idx_r <= '0;
            wr_idx_r <= '0;
          end else begin
            holder_r <= holder_r >> fb;
            held_r   <= held_left;
            coord_r  <= coord_r + 12'd1;
            if (pos_inc >= glen) begin
              pos_r <= '0;
              if (rd_idx_r != GW'(MAX_GROUPS - 1)) rd_idx_r <= rd_idx_r + GW'(1);
            end else begin
              pos_r <= pos_inc[11:0];
            end
          end
          state_r <= S_FP_START;
        end
        S_FP_START: state_r <= S_FP_WAIT;
        S_FP_WAIT: begin
          if (fp_rsp.done) begin
            res_r   <= fp_rsp.value;
            state_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!ovalid_r || out_tready) begin
            ovalid_r <= 1'b1;
            oval_r   <= res_r;
            ocoord_r <= fcoord_r;
            olast_r  <= flast_r;
            oend_r   <= !more_r;
            state_r  <= more_r ? S_EXTRACT : S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {4'b0, ocoord_r, oval_r};
  assign out_tlast  = olast_r;
  assign out_tuser  = oend_r;

  `CHK_ASSERT(a_byte_extracts, clk, rst_n, (in_acc && in_tuser) |=> (state_r == S_EXTRACT), "byte beat did not start extraction")
  `CHK_ASSERT(a_enough_bits, clk, rst_n, (state_r == S_EXTRACT) |-> (held_r >= fb), "field extracted from too few bits")
  `CHK_ASSERT(a_done_expected, clk, rst_n, fp_rsp.done |-> (state_r == S_FP_WAIT), "multiply-add result with no field waiting")
  `CHK_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule
